// File: design/sha1_pkg.sv
// Package with the SHA-1 engine payload types and hash constants.
package sha1_pkg;

  // One accepted message word.
  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  byte_count;
    logic        last_word;
  } in_t;

  // One finished digest.
  typedef struct packed {
    logic [31:0] digest_h0;
    logic [31:0] digest_h1;
    logic [31:0] digest_h2;
    logic [31:0] digest_h3;
    logic [31:0] digest_h4;
  } out_t;

  // Initial chaining value.
  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  // Round constants, one for each group of twenty rounds.
  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  // Padding marker byte.
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Block geometry.
  localparam int unsigned BLOCK_WORDS = 16;
  localparam logic [6:0]  LAST_ROUND  = 7'd79;

endpackage

// File: design/sha1_hash_engine.sv
// SHA-1 hash engine: word intake, padding sequencer and one-round-per-cycle compression.
//
//   Channel | Direction | Payload            | Handshake
//   in_     | input     | sha1_pkg::in_t     | in_valid / in_stall
//   out_    | output    | sha1_pkg::out_t    | out_valid / out_stall
//
// Each non-final word is taken into the block buffer; every 16th word also
// starts a compression (one round per cycle through a single round adder)
// followed by the chaining add. A final word adds padding words, one or two
// more compressions and a load of the digest register.
// Reset returns the sequencer, the length counter and the chaining value to their start.
// in_stall is high whenever the sequencer is not waiting for a word; a held
// digest in the output register stalls the done state and with it the intake.
module sha1_hash_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sha1_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sha1_pkg::out_t out_data
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROUND = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_PAD   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]     state_r, state_nxt;
  logic [31:0]    chain_r [5];
  logic [31:0]    chain_nxt [5];
  logic [31:0]    var_r [5];
  logic [31:0]    var_nxt [5];
  logic [31:0]    w_r [16];
  logic [31:0]    w_nxt [16];
  logic [63:0]    bits_r, bits_nxt;
  logic [3:0]     fill_r, fill_nxt;
  logic [6:0]     round_r, round_nxt;
  logic           finishing_r, finishing_nxt;
  logic           pad_pending_r, pad_pending_nxt;
  logic           len_hi_done_r, len_hi_done_nxt;
  logic           len_done_r, len_done_nxt;
  logic           out_valid_r, out_valid_nxt;
  sha1_pkg::out_t out_data_r, out_data_nxt;

  logic           in_xfer;
  logic [2:0]     cnt_sat;
  logic           push_en;
  logic [31:0]    push_word;
  logic [31:0]    last_word_val;
  logic [31:0]    sched_x;
  logic [31:0]    sched_word;
  logic [31:0]    f_val;
  logic [31:0]    k_val;
  logic [31:0]    round_sum;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Saturated byte count and the final word with its pad byte merged in.
  always_comb begin
    cnt_sat = (in_data.byte_count > 3'd4) ? 3'd4 : in_data.byte_count;
    case (cnt_sat)
      3'd0:    last_word_val = {sha1_pkg::PAD_BYTE, 24'h0};
      3'd1:    last_word_val = {in_data.message_word[31:24], sha1_pkg::PAD_BYTE, 16'h0};
      3'd2:    last_word_val = {in_data.message_word[31:16], sha1_pkg::PAD_BYTE, 8'h0};
      3'd3:    last_word_val = {in_data.message_word[31:8], sha1_pkg::PAD_BYTE};
      default: last_word_val = in_data.message_word;
    endcase
  end

  // Message schedule tap and round function for the current round.
  always_comb begin
    sched_x    = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    sched_word = {sched_x[30:0], sched_x[31]};
    if (round_r < 7'd20) begin
      f_val = (var_r[1] & var_r[2]) | (~var_r[1] & var_r[3]);
      k_val = sha1_pkg::K_R0;
    end else if (round_r < 7'd40) begin
      f_val = var_r[1] ^ var_r[2] ^ var_r[3];
      k_val = sha1_pkg::K_R1;
    end else if (round_r < 7'd60) begin
      f_val = (var_r[1] & var_r[2]) | (var_r[1] & var_r[3]) | (var_r[2] & var_r[3]);
      k_val = sha1_pkg::K_R2;
    end else begin
      f_val = var_r[1] ^ var_r[2] ^ var_r[3];
      k_val = sha1_pkg::K_R3;
    end
    round_sum = {var_r[0][26:0], var_r[0][31:27]} + f_val + var_r[4] + k_val + w_r[0];
  end

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_nxt       = state_r;
    chain_nxt       = chain_r;
    var_nxt         = var_r;
    w_nxt           = w_r;
    bits_nxt        = bits_r;
    fill_nxt        = fill_r;
    round_nxt       = round_r;
    finishing_nxt   = finishing_r;
    pad_pending_nxt = pad_pending_r;
    len_hi_done_nxt = len_hi_done_r;
    len_done_nxt    = len_done_r;
    out_data_nxt    = out_data_r;
    out_valid_nxt   = out_valid_r;
    push_en         = 1'b0;
    push_word       = 32'h0;

    // A taken digest frees the output register.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          push_en = 1'b1;
          if (!in_data.last_word) begin
            push_word = in_data.message_word;
            bits_nxt  = bits_r + 64'd32;
          end else begin
            push_word       = last_word_val;
            bits_nxt        = bits_r + {58'h0, cnt_sat, 3'b000};
            finishing_nxt   = 1'b1;
            pad_pending_nxt = (cnt_sat == 3'd4);
            state_nxt       = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        if (pad_pending_r) begin
          push_word       = {sha1_pkg::PAD_BYTE, 24'h0};
          pad_pending_nxt = 1'b0;
        end else if (fill_r == 4'd14) begin
          push_word       = bits_r[63:32];
          len_hi_done_nxt = 1'b1;
        end else if (fill_r == 4'd15 && len_hi_done_r) begin
          push_word    = bits_r[31:0];
          len_done_nxt = 1'b1;
        end else begin
          push_word = 32'h0;
        end
      end
      ST_ROUND: begin
        // One round: shift the schedule window and rotate the working variables.
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i + 1];
        end
        w_nxt[15]  = sched_word;
        var_nxt[0] = round_sum;
        var_nxt[1] = var_r[0];
        var_nxt[2] = {var_r[1][1:0], var_r[1][31:2]};
        var_nxt[3] = var_r[2];
        var_nxt[4] = var_r[3];
        if (round_r == sha1_pkg::LAST_ROUND) begin
          round_nxt = 7'd0;
          state_nxt = ST_ADD;
        end else begin
          round_nxt = round_r + 7'd1;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 5; i++) begin
          chain_nxt[i] = chain_r[i] + var_r[i];
        end
        if (len_done_r) begin
          state_nxt = ST_DONE;
        end else if (finishing_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE: begin
        // Hand the digest to the output register once it is free.
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.digest_h0 = chain_r[0];
          out_data_nxt.digest_h1 = chain_r[1];
          out_data_nxt.digest_h2 = chain_r[2];
          out_data_nxt.digest_h3 = chain_r[3];
          out_data_nxt.digest_h4 = chain_r[4];
          out_valid_nxt   = 1'b1;
          chain_nxt[0]    = sha1_pkg::H0_INIT;
          chain_nxt[1]    = sha1_pkg::H1_INIT;
          chain_nxt[2]    = sha1_pkg::H2_INIT;
          chain_nxt[3]    = sha1_pkg::H3_INIT;
          chain_nxt[4]    = sha1_pkg::H4_INIT;
          bits_nxt        = 64'h0;
          finishing_nxt   = 1'b0;
          pad_pending_nxt = 1'b0;
          len_hi_done_nxt = 1'b0;
          len_done_nxt    = 1'b0;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Block buffer intake; a full block starts the compression.
    if (push_en) begin
      for (int i = 0; i < 15; i++) begin
        w_nxt[i] = w_r[i + 1];
      end
      w_nxt[15] = push_word;
      fill_nxt  = fill_r + 4'd1;
      if (fill_r == 4'd15) begin
        var_nxt   = chain_r;
        round_nxt = 7'd0;
        state_nxt = ST_ROUND;
      end
    end
  end

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      chain_r[0]    <= sha1_pkg::H0_INIT;
      chain_r[1]    <= sha1_pkg::H1_INIT;
      chain_r[2]    <= sha1_pkg::H2_INIT;
      chain_r[3]    <= sha1_pkg::H3_INIT;
      chain_r[4]    <= sha1_pkg::H4_INIT;
      bits_r        <= 64'h0;
      fill_r        <= 4'd0;
      round_r       <= 7'd0;
      finishing_r   <= 1'b0;
      pad_pending_r <= 1'b0;
      len_hi_done_r <= 1'b0;
      len_done_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      chain_r       <= chain_nxt;
      bits_r        <= bits_nxt;
      fill_r        <= fill_nxt;
      round_r       <= round_nxt;
      finishing_r   <= finishing_nxt;
      pad_pending_r <= pad_pending_nxt;
      len_hi_done_r <= len_hi_done_nxt;
      len_done_r    <= len_done_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    var_r      <= var_nxt;
    w_r        <= w_nxt;
    out_data_r <= out_data_nxt;
  end

  // The round counter never runs past the last round.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (round_r <= sha1_pkg::LAST_ROUND))
    else $error("round counter out of range");

  // The low length word is only placed after the high one.
  assert property (@(posedge clk) disable iff (!rst_n)
    len_done_r |-> (len_hi_done_r && finishing_r && !pad_pending_r))
    else $error("length words out of order");

  // A pending pad marker only exists while a message is being finished.
  assert property (@(posedge clk) disable iff (!rst_n)
    pad_pending_r |-> finishing_r)
    else $error("pad marker pending outside finishing");

  // A non-final word transfer returns to intake or starts a compression.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_data.last_word) |=> (state_r == ST_IDLE || state_r == ST_ROUND))
    else $error("unexpected state after a message word");

  // A digest is only loaded from the done state, with the length fully placed.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (len_done_r && fill_r == 4'd0))
    else $error("digest finished with an incomplete final block");

endmodule
